@@ hdl/wds_pkg.sv @@
`timescale 1ns / 1ps

package wds_pkg;

	// sample and state geometry
	localparam int SAMPLE_WIDTH        = 24;
	localparam int EXTRA_FRACTION_BITS = 16;
	localparam int NUM_CH              = 6;
	localparam int TRIPLE              = 3;
	localparam int ST_W                = SAMPLE_WIDTH + EXTRA_FRACTION_BITS;
	localparam int DIFF_W              = ST_W + 1;

	// gain multiply split: diff = hi * 2^16 + lo
	localparam int LO_W    = 16;
	localparam int HI_W    = DIFF_W - LO_W;
	localparam int RATE_W  = 17;
	localparam int GAIN_SW = RATE_W + 1;
	localparam int PH_W    = HI_W + GAIN_SW;
	localparam int PL_W    = LO_W + RATE_W;
	localparam int STEP_W  = PH_W + 1;

	// dead-zone length check
	localparam int SQ_W     = 2 * SAMPLE_WIDTH - 1;
	localparam int SUM_W    = 2 * SAMPLE_WIDTH;
	localparam int THR_W    = 16;
	localparam int THR_SQ_W = 2 * THR_W;
	localparam int CMP_W    = (SUM_W > THR_SQ_W) ? SUM_W : THR_SQ_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RATE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DZ    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_DZ   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_RATE = CFG_IDX_W'(2);

	localparam logic [RATE_W-1:0]   RATE_ONE     = RATE_W'(65536);
	localparam logic [RATE_W-1:0]   GAIN_RESET   = RATE_W'(65536 - 16384);
	localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(51 * 51);

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] force_x;
		logic signed [SAMPLE_WIDTH-1:0] force_y;
		logic signed [SAMPLE_WIDTH-1:0] force_z;
		logic signed [SAMPLE_WIDTH-1:0] torque_x;
		logic signed [SAMPLE_WIDTH-1:0] torque_y;
		logic signed [SAMPLE_WIDTH-1:0] torque_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] smooth_force_x;
		logic signed [SAMPLE_WIDTH-1:0] smooth_force_y;
		logic signed [SAMPLE_WIDTH-1:0] smooth_force_z;
		logic signed [SAMPLE_WIDTH-1:0] smooth_torque_x;
		logic signed [SAMPLE_WIDTH-1:0] smooth_torque_y;
		logic signed [SAMPLE_WIDTH-1:0] smooth_torque_z;
	} out_beat_t;

	// stage enables and dead-zone verdict for one lane
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic upd;
		logic zero;
	} lane_ctrl_t;

endpackage

@@ hdl/wds_lane.sv @@
`timescale 1ns / 1ps

module wds_lane (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  wds_pkg::lane_ctrl_t                       ctrl,
	input  logic [wds_pkg::RATE_W-1:0]                gain,
	input  logic signed [wds_pkg::SAMPLE_WIDTH-1:0]   x,
	output logic [wds_pkg::SQ_W-1:0]                  sq,
	output logic signed [wds_pkg::SAMPLE_WIDTH-1:0]   smooth
);

	logic signed [wds_pkg::SAMPLE_WIDTH-1:0]   x_s1;
	logic [wds_pkg::SQ_W-1:0]                  sq_s2;
	logic signed [wds_pkg::DIFF_W-1:0]         dk_s2;
	logic signed [wds_pkg::DIFF_W-1:0]         dz_s2;
	logic signed [wds_pkg::DIFF_W-1:0]         diff_s3;
	logic signed [wds_pkg::PH_W-1:0]           ph_s4;
	logic [wds_pkg::PL_W-1:0]                  pl_s4;
	logic signed [wds_pkg::ST_W-1:0]           state_q;

	logic signed [2*wds_pkg::SAMPLE_WIDTH-1:0] x_sq;
	logic signed [wds_pkg::ST_W-1:0]           target;
	logic signed [wds_pkg::HI_W-1:0]           hi;
	logic [wds_pkg::LO_W-1:0]                  lo;
	logic signed [wds_pkg::GAIN_SW-1:0]        gain_s;
	logic signed [wds_pkg::PH_W-1:0]           ph;
	logic [wds_pkg::PL_W-1:0]                  pl;
	logic signed [wds_pkg::STEP_W-1:0]         step;
	logic signed [wds_pkg::STEP_W-1:0]         nxt;

	// square of the sample and both candidate differences
	assign x_sq   = (2*wds_pkg::SAMPLE_WIDTH)'(x_s1) * (2*wds_pkg::SAMPLE_WIDTH)'(x_s1);
	assign target = wds_pkg::ST_W'(x_s1) <<< wds_pkg::EXTRA_FRACTION_BITS;

	// gain multiply in two partial products, floor of the low part kept exact
	assign hi     = diff_s3[wds_pkg::DIFF_W-1:wds_pkg::LO_W];
	assign lo     = diff_s3[wds_pkg::LO_W-1:0];
	assign gain_s = $signed({1'b0, gain});
	assign ph     = wds_pkg::PH_W'(gain_s) * wds_pkg::PH_W'(hi);
	assign pl     = wds_pkg::PL_W'(gain) * wds_pkg::PL_W'(lo);

	// state moves towards the target; the mix never leaves the state range
	assign step = wds_pkg::STEP_W'(ph_s4)
		+ wds_pkg::STEP_W'($signed({1'b0, pl_s4[wds_pkg::PL_W-1:wds_pkg::LO_W]}));
	assign nxt  = wds_pkg::STEP_W'(state_q) + step;

	// datapath stages
	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			x_s1 <= x;
		end
		if (ctrl.en_s2) begin
			sq_s2 <= x_sq[wds_pkg::SQ_W-1:0];
			dk_s2 <= wds_pkg::DIFF_W'(target) - wds_pkg::DIFF_W'(state_q);
			dz_s2 <= -wds_pkg::DIFF_W'(state_q);
		end
		if (ctrl.en_s3) begin
			diff_s3 <= ctrl.zero ? dz_s2 : dk_s2;
		end
		if (ctrl.en_s4) begin
			ph_s4 <= ph;
			pl_s4 <= pl;
		end
	end

	// smoother state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctrl.upd) begin
			state_q <= nxt[wds_pkg::ST_W-1:0];
		end
	end

	assign sq     = sq_s2;
	assign smooth = state_q[wds_pkg::ST_W-1:wds_pkg::EXTRA_FRACTION_BITS];

endmodule

@@ hdl/wds_merge.sv @@
`timescale 1ns / 1ps

module wds_merge (
	input  logic [wds_pkg::SQ_W-1:0]     sq_a,
	input  logic [wds_pkg::SQ_W-1:0]     sq_b,
	input  logic [wds_pkg::SQ_W-1:0]     sq_c,
	input  logic [wds_pkg::THR_SQ_W-1:0] thr_sq,
	output logic                         zero
);

	logic [wds_pkg::SUM_W-1:0] len_sq;

	// squared length of the triple against the squared threshold
	assign len_sq = wds_pkg::SUM_W'(sq_a) + wds_pkg::SUM_W'(sq_b) + wds_pkg::SUM_W'(sq_c);
	assign zero   = wds_pkg::CMP_W'(len_sq) < wds_pkg::CMP_W'(thr_sq);

endmodule

@@ hdl/wrench_deadzone_smoother_core.sv @@
`timescale 1ns / 1ps

// Six-axis wrench dead-zone and smoothing filter.
// Input channel (in_valid/in_ready/in_data) takes one force/torque sample per
// beat; output channel (out_valid/out_ready/out_data) returns one smoothed
// sample per input beat, in order.
// Six lanes, one per axis, square their element, take the gain difference and
// update their own smoother state; a merging stage per triple sums the squares
// and decides the dead zone.
// Flow: an accepted beat passes the four pipeline stages (input, square and
// difference, difference select, partial products) and then updates the state
// registers that drive out_data. One sample is in flight at a time: a new beat
// is taken only once the last result has been raised and is being taken.
// The smoothed state registers drive out_data directly; while the receiver
// stalls, out_data holds and in_ready stays low.
// Configuration (cfg_we/cfg_index/cfg_wdata) is to be written only while idle,
// which the block does not enforce; thresholds are stored squared, rate as gain.
// Reset: all smoother states are cleared, thresholds return to 51 and the rate
// to 16384; the block is ready on the first cycle after reset.
module wrench_deadzone_smoother_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  wds_pkg::in_beat_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wds_pkg::out_beat_t                  out_data,
	input  logic                                cfg_we,
	input  logic [wds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	logic                            v_s1, v_s2, v_s3, v_s4;
	logic                            out_valid_q;
	logic [wds_pkg::THR_SQ_W-1:0]    force_thr_sq_q;
	logic [wds_pkg::THR_SQ_W-1:0]    torque_thr_sq_q;
	logic [wds_pkg::RATE_W-1:0]      gain_q;

	logic                            accept;
	logic                            force_zero;
	logic                            torque_zero;
	wds_pkg::lane_ctrl_t             force_ctrl;
	wds_pkg::lane_ctrl_t             torque_ctrl;
	logic [wds_pkg::THR_SQ_W-1:0]    wr_thr_sq;
	logic [wds_pkg::RATE_W-1:0]      wr_gain;

	logic signed [wds_pkg::SAMPLE_WIDTH-1:0] x_in   [wds_pkg::NUM_CH];
	logic signed [wds_pkg::SAMPLE_WIDTH-1:0] smooth [wds_pkg::NUM_CH];
	logic [wds_pkg::SQ_W-1:0]                sq     [wds_pkg::NUM_CH];

	// handshake
	assign accept    = in_valid && in_ready;
	assign in_ready  = !(v_s1 || v_s2 || v_s3 || v_s4) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// stage valids and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration: thresholds kept squared, rate kept as gain
	assign wr_thr_sq = wds_pkg::THR_SQ_W'(cfg_wdata[wds_pkg::THR_W-1:0])
		* wds_pkg::THR_SQ_W'(cfg_wdata[wds_pkg::THR_W-1:0]);
	assign wr_gain   = (cfg_wdata > wds_pkg::RATE_ONE) ? '0 : wds_pkg::RATE_ONE - cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_thr_sq_q  <= wds_pkg::THR_SQ_RESET;
			torque_thr_sq_q <= wds_pkg::THR_SQ_RESET;
			gain_q          <= wds_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wds_pkg::CFG_FORCE_DZ: begin
					force_thr_sq_q <= wr_thr_sq;
				end
				wds_pkg::CFG_TORQUE_DZ: begin
					torque_thr_sq_q <= wr_thr_sq;
				end
				wds_pkg::CFG_FILTER_RATE: begin
					gain_q <= wr_gain;
				end
				default: begin
				end
			endcase
		end
	end

	// dead-zone merge per triple
	wds_merge u_force_merge (
		.sq_a   (sq[0]),
		.sq_b   (sq[1]),
		.sq_c   (sq[2]),
		.thr_sq (force_thr_sq_q),
		.zero   (force_zero)
	);

	wds_merge u_torque_merge (
		.sq_a   (sq[3]),
		.sq_b   (sq[4]),
		.sq_c   (sq[5]),
		.thr_sq (torque_thr_sq_q),
		.zero   (torque_zero)
	);

	// lane control
	always_comb begin
		force_ctrl.en_s1  = accept;
		force_ctrl.en_s2  = v_s1;
		force_ctrl.en_s3  = v_s2;
		force_ctrl.en_s4  = v_s3;
		force_ctrl.upd    = v_s4;
		force_ctrl.zero   = force_zero;
		torque_ctrl       = force_ctrl;
		torque_ctrl.zero  = torque_zero;
	end

	// lane inputs
	assign x_in[0] = in_data.force_x;
	assign x_in[1] = in_data.force_y;
	assign x_in[2] = in_data.force_z;
	assign x_in[3] = in_data.torque_x;
	assign x_in[4] = in_data.torque_y;
	assign x_in[5] = in_data.torque_z;

	// one lane per axis
	for (genvar i = 0; i < wds_pkg::NUM_CH; i++) begin : g_lane
		wds_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   ((i < wds_pkg::TRIPLE) ? force_ctrl : torque_ctrl),
			.gain   (gain_q),
			.x      (x_in[i]),
			.sq     (sq[i]),
			.smooth (smooth[i])
		);
	end

	// result beat straight from the smoother states
	assign out_data.smooth_force_x  = smooth[0];
	assign out_data.smooth_force_y  = smooth[1];
	assign out_data.smooth_force_z  = smooth[2];
	assign out_data.smooth_torque_x = smooth[3];
	assign out_data.smooth_torque_y = smooth[4];
	assign out_data.smooth_torque_z = smooth[5];

	// at most one sample anywhere in the pipe or waiting at the output
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3, v_s4, out_valid_q}))
		else $error("more than one sample in flight");

	// an accepted beat reaches the state update without stalling
	a_update_timing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 v_s4)
		else $error("accepted beat did not reach the update stage");

	// the update always raises the result
	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> out_valid_q)
		else $error("state update without result");

	// a waiting result keeps its smoother states
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && !v_s4 |=> $stable(out_data))
		else $error("smoother state changed under a stalled result");

	// gain never exceeds one
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= wds_pkg::RATE_ONE)
		else $error("gain above one");

endmodule
